>>> hdl/fepb_pkg.sv
// Shared types and constants for the flash envelope pixel blend.
package fepb_pkg;

    // Register clamps and envelope limits
    localparam logic [3:0] ATTACK_MAX  = 4'd10;
    localparam logic [3:0] SUSTAIN_MAX = 4'd10;
    localparam logic [4:0] DECAY_MAX   = 5'd25;
    localparam logic [5:0] TOTAL_MAX   = 6'd45;

    // Fade arithmetic
    localparam int unsigned NUM_W      = 15;
    localparam logic [14:0] FADE_SPAN  = 15'd510;
    localparam logic [7:0]  FADE_FULL  = 8'd255;
    localparam int unsigned QUO_W      = 8;

    // Item kinds carried on tuser
    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_SUSTAIN = 2'd1,
        REG_DECAY   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [3:0] attack_frames;
        logic [3:0] sustain_frames;
        logic [4:0] decay_frames;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic        is_pixel;
        logic [31:0] trigger_word;
        pixel_t      pix;
    } item_t;

endpackage

>>> hdl/fepb_front.sv
// Front end: input stage that accepts and classifies stream items.
module fepb_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [55:0]     s_axis_tdata,   // trigger_word, red_in, green_in, blue_in
    input  logic            s_axis_tuser,   // mode
    input  logic            q_full,
    output logic            q_wr,
    output fepb_pkg::item_t q_item
);

    logic            stage_valid_reg;
    fepb_pkg::item_t stage_item_reg;
    fepb_pkg::item_t decoded;

    // Classify the incoming transaction; pixels carry no trigger, frames no color
    always_comb
    begin
        decoded = '0;
        decoded.is_pixel = (s_axis_tuser == fepb_pkg::MODE_PIXEL);
        if (decoded.is_pixel)
        begin
            decoded.pix.red   = s_axis_tdata[39:32];
            decoded.pix.green = s_axis_tdata[47:40];
            decoded.pix.blue  = s_axis_tdata[55:48];
        end
        else
        begin
            decoded.trigger_word = s_axis_tdata[31:0];
        end
    end

    // Stage drains into the queue whenever it has room
    assign q_wr          = stage_valid_reg && !q_full;
    assign q_item        = stage_item_reg;
    assign s_axis_tready = !stage_valid_reg || !q_full;

    // Hold one classified item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_item_reg  <= '0;
        end
        else if (s_axis_tready)
        begin
            stage_valid_reg <= s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                stage_item_reg <= decoded;
            end
        end
    end

endmodule

>>> hdl/fepb_queue.sv
// Short item queue between front and back end.
module fepb_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  fepb_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd,
    output logic            rd_valid,
    output fepb_pkg::item_t rd_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fepb_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/fepb_back.sv
// Back end: envelope update on frame starts and pixel blend toward white.
module fepb_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  fepb_pkg::cfg_t   cfg,
    input  logic             head_valid,
    input  fepb_pkg::item_t  head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output fepb_pkg::pixel_t out_pixel
);

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } state_t;

    state_t           state_reg;
    logic [31:0]      last_trigger_reg;
    logic [5:0]       frames_left_reg;
    logic [7:0]       fade_reg;
    logic             bypass_reg;
    logic             out_valid_reg;
    fepb_pkg::pixel_t out_pixel_reg;
    logic [14:0]      rem_reg;
    logic [12:0]      dsh_reg;
    logic [7:0]       quo_reg;
    logic [2:0]       step_reg;

    logic [3:0]  atk;
    logic [3:0]  sus;
    logic [4:0]  dec;
    logic [5:0]  total;
    logic [5:0]  atk_sus;
    logic        trig_changed;
    logic        bypass_hit;
    logic [5:0]  fl_eff;
    logic [5:0]  fl_dec;
    logic [5:0]  elapsed;
    logic        phase_attack;
    logic        phase_sustain;
    logic        need_div;
    logic [14:0] num;
    logic [5:0]  den;
    logic [7:0]  fade_now;
    logic        frame_pop;
    logic        pix_pop;
    logic        div_ge;
    logic [7:0]  quo_next;

    // Blend one channel toward white
    function automatic logic [7:0] blend(input logic [7:0] fade, input logic [7:0] p);
        logic [15:0] sum;
        sum = 16'(fade * fepb_pkg::FADE_FULL)
            + 16'(p * (fepb_pkg::FADE_FULL - fade));
        return sum[15:8];
    endfunction

    // Clamp registers and find the envelope phase
    always_comb
    begin
        atk = (cfg.attack_frames  > fepb_pkg::ATTACK_MAX)  ? fepb_pkg::ATTACK_MAX
                                                           : cfg.attack_frames;
        sus = (cfg.sustain_frames > fepb_pkg::SUSTAIN_MAX) ? fepb_pkg::SUSTAIN_MAX
                                                           : cfg.sustain_frames;
        dec = (cfg.decay_frames   > fepb_pkg::DECAY_MAX)   ? fepb_pkg::DECAY_MAX
                                                           : cfg.decay_frames;
        atk_sus       = {2'b00, atk} + {2'b00, sus};
        total         = atk_sus + {1'b0, dec};
        trig_changed  = (head.trigger_word != last_trigger_reg);
        bypass_hit    = !trig_changed && (frames_left_reg == '0);
        fl_eff        = trig_changed ? total : frames_left_reg;
        fl_dec        = (fl_eff == '0) ? '0 : fl_eff - 1'b1;
        elapsed       = (fl_eff > total) ? '0 : total - fl_eff;
        phase_attack  = (elapsed < {2'b00, atk});
        phase_sustain = (elapsed < atk_sus);
    end

    // Pick the fade directly or set up a division
    always_comb
    begin
        need_div = 1'b0;
        fade_now = '0;
        num      = fepb_pkg::NUM_W'(fl_eff) * fepb_pkg::FADE_SPAN + 1'b1;
        den      = {dec, 1'b0};
        if (phase_attack)
        begin
            need_div = 1'b1;
            num      = fepb_pkg::NUM_W'(elapsed) * fepb_pkg::FADE_SPAN + 1'b1;
            den      = {1'b0, atk, 1'b0};
        end
        else if (phase_sustain)
        begin
            fade_now = fepb_pkg::FADE_FULL;
        end
        else if (dec == '0)
        begin
            fade_now = '0;
        end
        else if (fl_eff >= {1'b0, dec})
        begin
            fade_now = fepb_pkg::FADE_FULL;
        end
        else
        begin
            need_div = 1'b1;
        end
    end

    // Queue head handling
    assign frame_pop = (state_reg == ST_RUN) && head_valid && !head.is_pixel;
    assign pix_pop   = (state_reg == ST_RUN) && head_valid && head.is_pixel
                       && (!out_valid_reg || out_ready);
    assign pop       = frame_pop || pix_pop;

    // One restoring division step
    assign div_ge   = (rem_reg >= {2'b00, dsh_reg});
    assign quo_next = {quo_reg[fepb_pkg::QUO_W-2:0], div_ge};

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    // State, envelope registers, divider and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            last_trigger_reg <= '0;
            frames_left_reg  <= '0;
            fade_reg         <= '0;
            bypass_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_pixel_reg    <= '0;
            rem_reg          <= '0;
            dsh_reg          <= '0;
            quo_reg          <= '0;
            step_reg         <= '0;
        end
        else
        begin
            // Drop the result once taken; reload on a new pixel
            if (pix_pop)
            begin
                out_valid_reg <= 1'b1;
                if (bypass_reg)
                begin
                    out_pixel_reg <= head.pix;
                end
                else
                begin
                    out_pixel_reg.red   <= blend(fade_reg, head.pix.red);
                    out_pixel_reg.green <= blend(fade_reg, head.pix.green);
                    out_pixel_reg.blue  <= blend(fade_reg, head.pix.blue);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_RUN:
                begin
                    if (frame_pop)
                    begin
                        if (bypass_hit)
                        begin
                            bypass_reg <= 1'b1;
                        end
                        else
                        begin
                            bypass_reg       <= 1'b0;
                            last_trigger_reg <= head.trigger_word;
                            frames_left_reg  <= fl_dec;
                            if (need_div)
                            begin
                                // First step weighs the top quotient bit
                                rem_reg   <= num;
                                dsh_reg   <= {den, 7'b0};
                                quo_reg   <= '0;
                                step_reg  <= 3'(fepb_pkg::QUO_W - 1);
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                fade_reg <= fade_now;
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - {2'b00, dsh_reg};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    quo_reg <= quo_next;
                    if (step_reg == '0)
                    begin
                        fade_reg  <= quo_next;
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // Nothing leaves the queue while a fade is being computed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !pop)
        else $error("queue popped during fade division");

    // A taken pixel always shows up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_pop |=> out_valid_reg)
        else $error("pixel lost between queue and output");

    // The last division step returns to normal running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == '0) |=> (state_reg == ST_RUN))
        else $error("divider overran its step count");

    // The frame counter never exceeds the longest envelope
    assert property (@(posedge clk) disable iff (!rst_n)
        frames_left_reg <= fepb_pkg::TOTAL_MAX)
        else $error("frame counter above envelope length");

endmodule

>>> hdl/flash_envelope_pixel_blend.sv
// Top level of the flash envelope pixel blend.
//
// A fade-to-white flash for a video stream, shaped by an attack, sustain and
// decay envelope counted in frames. Items enter on the s_axis channel:
// tuser low marks a frame start carrying a trigger word, tuser high a pixel.
// A frame start whose trigger differs from the stored one restarts the
// envelope and sets this frame's fade level; an unchanged trigger with the
// envelope run out makes the frame pass unchanged. Each pixel produces one
// transaction on m_axis with its blended RGB; frame starts produce none.
// Envelope lengths are written on the cfg channel, which is always ready;
// write them only while the stream is idle.
// An accepted item passes the input stage, the queue and the output
// register before output valid rises. Pixels sustain one per cycle while
// the receiver is ready and no fade division runs. A frame start whose
// fade needs the shared bit-serial divider (attack and partial decay
// frames) holds the queue until the division ends; pixels behind it wait
// in the queue meanwhile while the input keeps filling the queue.
// Reset clears the envelope state, fade level and all valid flags. When the
// receiver stalls, the output register holds and the queue and input stage
// fill before s_axis_tready drops.
module flash_envelope_pixel_blend
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // trigger_word, red_in, green_in, blue_in
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    fepb_pkg::cfg_t   cfg_reg;
    logic             q_wr;
    logic             q_full;
    fepb_pkg::item_t  q_in_item;
    logic             q_rd;
    logic             q_rd_valid;
    fepb_pkg::item_t  q_head;
    fepb_pkg::pixel_t out_pixel;

    assign cfg_ready = 1'b1;

    // Hold envelope configuration; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fepb_pkg::REG_ATTACK:  cfg_reg.attack_frames  <= cfg_data[3:0];
                fepb_pkg::REG_SUSTAIN: cfg_reg.sustain_frames <= cfg_data[3:0];
                fepb_pkg::REG_DECAY:   cfg_reg.decay_frames   <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    fepb_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_item        (q_in_item)
    );

    fepb_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_item  (q_in_item),
        .full     (q_full),
        .rd       (q_rd),
        .rd_valid (q_rd_valid),
        .rd_item  (q_head)
    );

    fepb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_rd_valid),
        .head       (q_head),
        .pop        (q_rd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_pixel  (out_pixel)
    );

    // Pack result, red in the lowest byte
    assign m_axis_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};

endmodule

>>> tb/flash_envelope_pixel_blend_test.sv
// Testbench for the flash envelope pixel blend: stream stimulus, envelope predictor, checks.
module flash_envelope_pixel_blend_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that no register answers to
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int MAX_REPORTS = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;     // trigger_word, red_in, green_in, blue_in
    logic        s_axis_tuser = 1'b0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // red_out, green_out, blue_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    // Stimulus and expectations
    fepb_pkg::item_t  stim_q[$];
    fepb_pkg::item_t  cur_item;
    fepb_pkg::pixel_t pixel_exp_q[$];
    int     pushed_cnt = 0;
    int     accepted_cnt = 0;
    bit     in_taken = 1'b0;
    int     send_wait = 0;
    int     send_calm = 0;
    int     recv_wait = 0;
    int     recv_calm = 0;

    // Predictor copy of the registers and envelope state
    logic [3:0]  attack_reg = '0;
    logic [3:0]  sustain_reg = '0;
    logic [4:0]  decay_reg = '0;
    logic [31:0] env_trigger = '0;
    logic [5:0]  env_left = '0;
    logic [7:0]  env_fade = '0;
    logic        env_bypass = 1'b0;

    // Run statistics
    int errors = 0;
    int pixel_cnt = 0;
    int frame_cnt = 0;
    int bypass_cnt = 0;
    int write_cnt = 0;

    string chan_name[3] = '{"red", "green", "blue"};

    flash_envelope_pixel_blend u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle cycles before the next transaction, with calm stretches of none
    function automatic int draw_idle(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Mix one channel toward white by the fade level
    function automatic logic [7:0] blend_to_white(logic [7:0] fade, logic [7:0] p);
        int unsigned f;
        int unsigned v;
        f = fade;
        v = p;
        return 8'((f * fepb_pkg::FADE_FULL + v * (fepb_pkg::FADE_FULL - f)) >> 8);
    endfunction

    // Step the envelope on a frame start and set this frame's fade or bypass
    task automatic advance_envelope(input logic [31:0] trig);
        int unsigned atk;
        int unsigned sus;
        int unsigned dec;
        int unsigned total;
        int unsigned elapsed;
        int unsigned f;
        atk = (attack_reg > fepb_pkg::ATTACK_MAX) ? fepb_pkg::ATTACK_MAX : attack_reg;
        sus = (sustain_reg > fepb_pkg::SUSTAIN_MAX) ? fepb_pkg::SUSTAIN_MAX : sustain_reg;
        dec = (decay_reg > fepb_pkg::DECAY_MAX) ? fepb_pkg::DECAY_MAX : decay_reg;
        total = atk + sus + dec;
        frame_cnt++;
        if (trig == env_trigger && env_left == 0)
        begin
            env_bypass = 1'b1;
            bypass_cnt++;
        end
        else
        begin
            env_bypass = 1'b0;
            if (trig != env_trigger)
            begin
                env_left = 6'(total);
                env_trigger = trig;
            end
            elapsed = (env_left > total) ? 0 : total - env_left;
            if (elapsed < atk)
                f = (fepb_pkg::FADE_SPAN * elapsed + 1) / (2 * atk);
            else if (elapsed < atk + sus)
                f = fepb_pkg::FADE_FULL;
            else if (dec == 0)
                f = 0;
            else
            begin
                f = (fepb_pkg::FADE_SPAN * env_left + 1) / (2 * dec);
                if (f > fepb_pkg::FADE_FULL)
                    f = fepb_pkg::FADE_FULL;
            end
            env_fade = f[7:0];
            if (env_left != 0)
                env_left = env_left - 6'd1;
        end
    endtask

    // Work out the result, if any, of one accepted item
    task automatic predict_item(input fepb_pkg::item_t it);
        fepb_pkg::pixel_t px;
        if (it.is_pixel == fepb_pkg::MODE_FRAME)
            advance_envelope(it.trigger_word);
        else
        begin
            if (env_bypass)
                px = it.pix;
            else
            begin
                px.red   = blend_to_white(env_fade, it.pix.red);
                px.green = blend_to_white(env_fade, it.pix.green);
                px.blue  = blend_to_white(env_fade, it.pix.blue);
            end
            pixel_exp_q.push_back(px);
        end
    endtask

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // Compare one output transaction with the oldest expected pixel
    task automatic check_pixel(input logic [23:0] data);
        fepb_pkg::pixel_t want;
        logic [7:0]       want_ch[3];
        logic [7:0]       got_ch[3];
        if (pixel_exp_q.size() == 0)
            report_error($sformatf("unexpected output transaction, tdata %h", data));
        else
        begin
            want = pixel_exp_q.pop_front();
            pixel_cnt++;
            want_ch = '{want.red, want.green, want.blue};
            got_ch  = '{data[7:0], data[15:8], data[23:16]};
            for (int k = 0; k < 3; k++)
            begin
                if (got_ch[k] !== want_ch[k])
                    report_error($sformatf("pixel %0d %s: expected %0d, got %0d",
                        pixel_cnt, chan_name[k], want_ch[k], got_ch[k]));
            end
        end
    endtask

    // Sample handshakes: check outputs, predict inputs, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_pixel(m_axis_tdata);
                recv_wait = draw_idle(recv_calm);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_taken = 1'b1;
                accepted_cnt++;
                predict_item(cur_item);
            end
            if (cfg_valid && cfg_ready)
            begin
                write_cnt++;
                case (cfg_index)
                    fepb_pkg::REG_ATTACK:  attack_reg = cfg_data[3:0];
                    fepb_pkg::REG_SUSTAIN: sustain_reg = cfg_data[3:0];
                    fepb_pkg::REG_DECAY:   decay_reg = cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    // Drive items from the pending queue, hold until taken, idle between
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (send_wait > 0)
            begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (rst_n && stim_q.size() > 0)
            begin
                cur_item = stim_q.pop_front();
                s_axis_tuser  <= cur_item.is_pixel;
                s_axis_tdata  <= {cur_item.pix.blue, cur_item.pix.green,
                                  cur_item.pix.red, cur_item.trigger_word};
                s_axis_tvalid <= 1'b1;
                send_wait = draw_idle(send_calm);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Stall the result side for the drawn number of cycles after each transaction
    always @(negedge clk)
    begin
        if (recv_wait > 0)
        begin
            recv_wait--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_frame(input logic [31:0] trig);
        fepb_pkg::item_t it;
        it.is_pixel = fepb_pkg::MODE_FRAME;
        it.trigger_word = trig;
        it.pix = {pick_channel(), pick_channel(), pick_channel()};
        stim_q.push_back(it);
        pushed_cnt++;
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        fepb_pkg::item_t it;
        it.is_pixel = fepb_pkg::MODE_PIXEL;
        it.trigger_word = $urandom;
        it.pix.red = r;
        it.pix.green = g;
        it.pix.blue = b;
        stim_q.push_back(it);
        pushed_cnt++;
    endtask

    // Hold until every item is taken and every result is in, then let the divider settle
    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || pixel_exp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] trig;
        logic [31:0] prev_trig;
        logic [31:0] pick;
        int          phase_items;
        int          pix_n;
        int          roll;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pixel ahead of any frame start, then an idle trigger, then an empty envelope
        queue_pixel(8'h00, 8'hFF, 8'h5A);
        queue_frame(32'h0000_0000);
        queue_pixel(8'hFF, 8'h00, 8'h81);
        queue_frame(32'h0000_0001);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // Raw values above the clamps, then a write to an unused index
        write_reg(fepb_pkg::REG_ATTACK, 5'h1F);
        write_reg(fepb_pkg::REG_SUSTAIN, 5'h1F);
        write_reg(fepb_pkg::REG_DECAY, 5'h1F);
        write_reg(REG_NONE, 5'h00);
        for (int k = 0; k < 4; k++)
        begin
            queue_frame(32'hFFFF_FFFF);
            queue_pixel(8'h00, 8'hFF, 8'h80);
            queue_pixel(8'h01, 8'hFE, 8'h7F);
        end
        wait_idle();

        // Lower the registers mid-envelope: counter above total, decay fade saturates
        write_reg(fepb_pkg::REG_ATTACK, 5'h00);
        write_reg(fepb_pkg::REG_SUSTAIN, 5'h00);
        write_reg(fepb_pkg::REG_DECAY, 5'h02);
        queue_frame(32'hFFFF_FFFF);
        queue_pixel(8'h00, 8'h80, 8'hFF);
        queue_frame(32'hFFFF_FFFF);
        queue_pixel(8'hFF, 8'h00, 8'h40);

        // Random phases: frames of a few pixels, mostly steady triggers
        trig = 32'hFFFF_FFFF;
        prev_trig = 32'h0000_0001;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(fepb_pkg::REG_ATTACK, 5'd0);
                    write_reg(fepb_pkg::REG_SUSTAIN, 5'd0);
                    write_reg(fepb_pkg::REG_DECAY, 5'd0);
                end
                1:
                begin
                    write_reg(fepb_pkg::REG_ATTACK, 5'd10);
                    write_reg(fepb_pkg::REG_SUSTAIN, 5'd10);
                    write_reg(fepb_pkg::REG_DECAY, 5'd25);
                end
                2:
                begin
                    write_reg(fepb_pkg::REG_ATTACK, 5'd1);
                    write_reg(fepb_pkg::REG_SUSTAIN, 5'd0);
                    write_reg(fepb_pkg::REG_DECAY, 5'd1);
                end
                default:
                begin
                    write_reg(fepb_pkg::REG_ATTACK, 5'($urandom_range(0, 31)));
                    write_reg(fepb_pkg::REG_SUSTAIN, 5'($urandom_range(0, 31)));
                    write_reg(fepb_pkg::REG_DECAY, 5'($urandom_range(0, 31)));
                    if ($urandom_range(0, 2) == 0)
                        write_reg(REG_NONE, 5'($urandom_range(0, 31)));
                end
            endcase

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    pick = trig;
                else if (roll < 85)
                    pick = $urandom;
                else if (roll < 91)
                    pick = 32'h0000_0000;
                else if (roll < 95)
                    pick = 32'hFFFF_FFFF;
                else
                    pick = prev_trig;
                if (pick != trig)
                begin
                    prev_trig = trig;
                    trig = pick;
                end
                queue_frame(pick);
                pix_n = $urandom_range(0, 6);
                for (int k = 0; k < pix_n; k++)
                    queue_pixel(pick_channel(), pick_channel(), pick_channel());
                phase_items += pix_n + 1;
            end
        end

        wait_idle();
        $display("Checked %0d pixel transactions over %0d frame starts (%0d bypassed),",
            pixel_cnt, frame_cnt, bypass_cnt);
        $display("with %0d register writes across %0d settings; %0d mismatches.",
            write_cnt, RANDOM_PHASES + 3, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still expected", pixel_exp_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
